>>> rtl/mcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse codec package
// Beat types, result kinds and the international code table for the codec.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int MAX_CODE_LEN_DEF = 6;
    localparam int NUM_CODES        = 42;
    // Widths of the code length and pattern inputs that the decode lookup accepts.
    localparam int LEN_HI_W         = 4;
    localparam int PAT_HI_W         = 8;

    localparam logic [7:0] BYTE_DOT   = 8'h2E;
    localparam logic [7:0] BYTE_DASH  = 8'h2D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [6:0] CHAR_SPACE = 7'h20;

    typedef enum logic [2:0] {
        KIND_DOT     = 3'd0,
        KIND_DASH    = 3'd1,
        KIND_GAP     = 3'd2,
        KIND_UNKNOWN = 3'd3,
        KIND_CHAR    = 3'd4,
        KIND_STATUS  = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] char_out;
        logic       ok;
        logic       last_of_run;
    } t_out_beat;

    // One table entry; pattern bit i is symbol i, 1 = dash.
    typedef struct packed {
        logic [6:0] glyph;
        logic [2:0] len;
        logic [5:0] pat;
    } t_code_ent;

    typedef struct packed {
        logic       hit;
        logic [2:0] len;
        logic [5:0] pat;
    } t_enc_res;

    typedef struct packed {
        logic       hit;
        logic [6:0] glyph;
    } t_dec_res;

    localparam t_code_ent CODE_TABLE [NUM_CODES] = '{
        '{7'h61, 3'd2, 6'd2 }, '{7'h62, 3'd4, 6'd1 }, '{7'h63, 3'd4, 6'd5 },
        '{7'h64, 3'd3, 6'd1 }, '{7'h65, 3'd1, 6'd0 }, '{7'h66, 3'd4, 6'd4 },
        '{7'h67, 3'd3, 6'd3 }, '{7'h68, 3'd4, 6'd0 }, '{7'h69, 3'd2, 6'd0 },
        '{7'h6A, 3'd4, 6'd14}, '{7'h6B, 3'd3, 6'd5 }, '{7'h6C, 3'd4, 6'd2 },
        '{7'h6D, 3'd2, 6'd3 }, '{7'h6E, 3'd2, 6'd1 }, '{7'h6F, 3'd3, 6'd7 },
        '{7'h70, 3'd4, 6'd6 }, '{7'h71, 3'd4, 6'd11}, '{7'h72, 3'd3, 6'd2 },
        '{7'h73, 3'd3, 6'd0 }, '{7'h74, 3'd1, 6'd1 }, '{7'h75, 3'd3, 6'd4 },
        '{7'h76, 3'd4, 6'd8 }, '{7'h77, 3'd3, 6'd6 }, '{7'h78, 3'd4, 6'd9 },
        '{7'h79, 3'd4, 6'd13}, '{7'h7A, 3'd4, 6'd3 },
        '{7'h30, 3'd5, 6'd31}, '{7'h31, 3'd5, 6'd30}, '{7'h32, 3'd5, 6'd28},
        '{7'h33, 3'd5, 6'd24}, '{7'h34, 3'd5, 6'd16}, '{7'h35, 3'd5, 6'd0 },
        '{7'h36, 3'd5, 6'd1 }, '{7'h37, 3'd5, 6'd3 }, '{7'h38, 3'd5, 6'd7 },
        '{7'h39, 3'd5, 6'd15},
        '{7'h2F, 3'd5, 6'd9 }, '{7'h3F, 3'd6, 6'd12}, '{7'h2C, 3'd6, 6'd51},
        '{7'h2E, 3'd6, 6'd42}, '{7'h2B, 3'd5, 6'd10}, '{7'h3D, 3'd5, 6'd17}
    };

    function automatic t_enc_res enc_lookup(input logic [7:0] b);
        t_enc_res res;
        res = '0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if ({1'b0, CODE_TABLE[i].glyph} == b) begin
                res.hit = 1'b1;
                res.len = CODE_TABLE[i].len;
                res.pat = CODE_TABLE[i].pat;
            end
        end
        return res;
    endfunction

    function automatic t_dec_res dec_lookup(input logic [LEN_HI_W-1:0] len,
                                            input logic [PAT_HI_W-1:0] pat);
        t_dec_res res;
        res = '0;
        for (int i = 0; i < NUM_CODES; i++) begin
            if (len == LEN_HI_W'(CODE_TABLE[i].len) &&
                pat == PAT_HI_W'(CODE_TABLE[i].pat)) begin
                res.hit   = 1'b1;
                res.glyph = CODE_TABLE[i].glyph;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/morse_code_codec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse code codec unit
// Encodes ASCII bytes to dot/dash/gap symbols, or decodes symbol bytes to
// characters with a sticky per-message failure flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one byte beat with an
//   end-of-message flag. Output channel (o_out_valid / i_out_ready / o_out)
//   gives zero to seven result beats per input beat; last_of_run marks the
//   final one. The config channel (i_cfg_valid / o_cfg_ready / i_cfg_data)
//   writes the mode bit (0 encode, 1 decode) and is ready whenever reset is
//   released; write it only while the block is idle.
//   Each item passes through an execute state and then the emit sequencer,
//   which puts out one result beat per cycle while the receiver takes them
//   (up to 7 beats for a six-symbol code plus its gap).
//   o_in_ready rises again once the last beat sits in the output register,
//   so the next byte can be taken while that beat still waits for the
//   receiver.
//   Decoder context (pattern, length, pending space, failed) lives in a
//   one-entry synchronous memory, read when a byte is accepted and written
//   back in the cycle after, so reads never overlap a pending write.
//   Reset clears the mode, the context valid bit (context reads as zero) and
//   the output valid bit. A stalled receiver holds the emit sequencer.
// ----------------------------------------------------------------------------
module morse_code_codec_unit #(
    parameter int MAX_CODE_LEN = mcc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mcc_pkg::t_in_beat i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mcc_pkg::t_out_beat o_out
);
    import mcc_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 2);
    localparam int CTX_W = MAX_CODE_LEN + LEN_W + 2;
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_CODE_LEN);
    localparam logic [LEN_W-1:0] LEN_SPOIL = LEN_W'(MAX_CODE_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic                r_mode;
    logic                r_item_mode;
    t_in_beat            r_item;

    // context memory: {failed, pending, length, pattern}
    logic [CTX_W-1:0]    r_ctx_mem [1];
    logic                r_ctx_vld;
    logic [CTX_W-1:0]    r_rd_ctx;

    // emit sequencer
    logic [2:0]          r_sym_cnt;
    logic [5:0]          r_sym_pat;
    logic                r_t0_vld;
    t_kind               r_t0_kind;
    logic [6:0]          r_t0_char;
    logic                r_t1_vld;
    t_kind               r_t1_kind;
    logic                r_ok;

    logic                r_out_vld;
    t_out_beat           r_out;

    // EXEC results
    logic [MAX_CODE_LEN-1:0] n_pat;
    logic [LEN_W-1:0]    n_len;
    logic                n_pend;
    logic                n_fail;
    logic [CTX_W-1:0]    n_ctx;
    logic [2:0]          n_sym_cnt;
    logic [5:0]          n_sym_pat;
    logic                n_t0_vld;
    t_kind               n_t0_kind;
    logic [6:0]          n_t0_char;
    logic                n_t1_vld;
    t_kind               n_t1_kind;
    logic                n_ok;

    logic [MAX_CODE_LEN-1:0] rd_pat;
    logic [LEN_W-1:0]    rd_len;
    logic                rd_pend;
    logic                rd_fail;
    t_enc_res            enc;
    t_dec_res            dec;

    logic                in_fire;
    logic                out_free;
    logic                have_beat;

    assign o_cfg_ready = i_rst_n;
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign out_free    = !r_out_vld || i_out_ready;
    assign have_beat   = (r_sym_cnt != 3'd0) || r_t0_vld || r_t1_vld;

    assign rd_pat  = r_rd_ctx[MAX_CODE_LEN-1:0];
    assign rd_len  = r_rd_ctx[MAX_CODE_LEN +: LEN_W];
    assign rd_pend = r_rd_ctx[CTX_W-2];
    assign rd_fail = r_rd_ctx[CTX_W-1];

    assign enc = enc_lookup(r_item.in_byte);
    assign dec = dec_lookup(LEN_HI_W'(rd_len), PAT_HI_W'(rd_pat));

    // Context memory: read on accept, write back in EXEC for decode items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx_vld <= 1'b0;
        end else if (r_state == S_EXEC && r_item_mode) begin
            r_ctx_vld <= 1'b1;
        end
        if (r_state == S_EXEC && r_item_mode) begin
            r_ctx_mem[0] <= n_ctx;
        end
        if (in_fire) begin
            r_rd_ctx <= r_ctx_vld ? r_ctx_mem[0] : '0;
        end
    end

    // Work out the new decoder context and the run of result beats.
    always_comb begin
        n_pat     = rd_pat;
        n_len     = rd_len;
        n_pend    = rd_pend;
        n_fail    = rd_fail;
        n_sym_cnt = 3'd0;
        n_sym_pat = 6'd0;
        n_t0_vld  = 1'b0;
        n_t0_kind = KIND_GAP;
        n_t0_char = 7'd0;
        n_t1_vld  = 1'b0;
        n_t1_kind = KIND_GAP;

        if (!r_item_mode) begin
            if (r_item.in_byte == BYTE_SPACE) begin
                n_t0_vld = 1'b1;
                n_t1_vld = 1'b1;
            end else if (enc.hit) begin
                n_sym_cnt = enc.len;
                n_sym_pat = enc.pat;
                n_t0_vld  = 1'b1;
            end else begin
                n_t0_vld  = 1'b1;
                n_t0_kind = KIND_UNKNOWN;
            end
        end else begin
            if (r_item.in_byte == BYTE_DOT || r_item.in_byte == BYTE_DASH) begin
                if (rd_pend) begin
                    n_fail = 1'b1;
                    n_pend = 1'b0;
                end
                if (rd_len >= LEN_MAX) begin
                    n_fail = 1'b1;
                    n_len  = LEN_SPOIL;
                end else begin
                    if (r_item.in_byte == BYTE_DASH) begin
                        n_pat = rd_pat | (MAX_CODE_LEN'(1) << rd_len);
                    end
                    n_len = rd_len + LEN_W'(1);
                end
            end else if (r_item.in_byte == BYTE_SPACE) begin
                if (rd_len != '0) begin
                    if (rd_len <= LEN_MAX && dec.hit) begin
                        n_t0_vld  = 1'b1;
                        n_t0_kind = KIND_CHAR;
                        n_t0_char = dec.glyph;
                    end else begin
                        n_fail = 1'b1;
                    end
                    n_len = '0;
                    n_pat = '0;
                end else if (rd_pend) begin
                    n_t0_vld  = 1'b1;
                    n_t0_kind = KIND_CHAR;
                    n_t0_char = CHAR_SPACE;
                    n_pend    = 1'b0;
                end else begin
                    n_pend = 1'b1;
                end
            end else begin
                n_pend = 1'b0;
                n_fail = 1'b1;
            end

            if (r_item.end_of_message) begin
                if (n_pend || n_len != '0) begin
                    n_fail = 1'b1;
                end
                n_t1_vld  = 1'b1;
                n_t1_kind = KIND_STATUS;
            end
        end

        n_ok = !n_fail;
        // end of message clears the whole context
        if (r_item_mode && r_item.end_of_message) begin
            n_ctx = '0;
        end else begin
            n_ctx = {n_fail, n_pend, n_len, n_pat};
        end
    end

    // Control sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b0;
            r_out_vld <= 1'b0;
            r_sym_cnt <= 3'd0;
            r_t0_vld  <= 1'b0;
            r_t1_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            // drop the taken beat unless the sequencer refills the register
            if (r_out_vld && i_out_ready && !(r_state == S_EMIT && have_beat)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_item      <= i_in;
                        r_item_mode <= r_mode;
                        r_state     <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_sym_cnt <= n_sym_cnt;
                    r_sym_pat <= n_sym_pat;
                    r_t0_vld  <= n_t0_vld;
                    r_t0_kind <= n_t0_kind;
                    r_t0_char <= n_t0_char;
                    r_t1_vld  <= n_t1_vld;
                    r_t1_kind <= n_t1_kind;
                    r_ok      <= r_item_mode ? n_ok : !rd_fail;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (!have_beat) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out.ok  <= r_ok;
                        if (r_sym_cnt != 3'd0) begin
                            // shift out symbols, LSB first
                            r_out.kind        <= r_sym_pat[0] ? KIND_DASH : KIND_DOT;
                            r_out.char_out    <= 7'd0;
                            r_out.last_of_run <= (r_sym_cnt == 3'd1) && !r_t0_vld
                                                 && !r_t1_vld;
                            r_sym_cnt         <= r_sym_cnt - 3'd1;
                            r_sym_pat         <= r_sym_pat >> 1;
                        end else if (r_t0_vld) begin
                            r_out.kind        <= r_t0_kind;
                            r_out.char_out    <= r_t0_char;
                            r_out.last_of_run <= !r_t1_vld;
                            r_t0_vld          <= 1'b0;
                        end else begin
                            r_out.kind        <= r_t1_kind;
                            r_out.char_out    <= 7'd0;
                            r_out.last_of_run <= 1'b1;
                            r_t1_vld          <= 1'b0;
                        end
                        if ((r_sym_cnt == 3'd0 && !r_t0_vld)
                            || (r_sym_cnt == 3'd1 && !r_t0_vld && !r_t1_vld)
                            || (r_sym_cnt == 3'd0 && r_t0_vld && !r_t1_vld)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
